/* hdl/ntu_pkg.sv */
// ----------------------------------------------------------------------------
// ntu_pkg
// Types and constants shared by the nearest track table update core.
// ----------------------------------------------------------------------------
package ntu_pkg;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [31:0]        stamp;
    logic [15:0]        payload;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  localparam logic [1:0] CMD_OBS   = 2'd0;
  localparam logic [1:0] CMD_SWEEP = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;
  localparam logic [1:0] CMD_NONE  = 2'd3;

  localparam logic [2:0] STAT_UPDATED  = 3'd0;
  localparam logic [2:0] STAT_INSERTED = 3'd1;
  localparam logic [2:0] STAT_DROPPED  = 3'd2;
  localparam logic [2:0] STAT_SWEEP    = 3'd3;
  localparam logic [2:0] STAT_READ     = 3'd4;

  localparam logic REG_RETENTION = 1'b0;
  localparam logic REG_RADIUS    = 1'b1;

  localparam logic [15:0] RETENTION_RESET = 16'd0;
  localparam logic [31:0] RADIUS_RESET    = 32'd1000000;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DISPATCH,
    S_AGE_A,
    S_AGE_B,
    S_MATCH_A,
    S_MATCH_B,
    S_MATCH_C,
    S_MATCH_D,
    S_MATCH_DEC,
    S_MRG_A,
    S_MRG_B,
    S_MRGJ_A,
    S_MRGJ_B,
    S_MRGJ_C,
    S_MRGJ_D,
    S_READ_A,
    S_READ_B,
    S_OUT
  } state_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_RD,
    OP_AGE_EVAL,
    OP_AGE_DONE,
    OP_DIFF,
    OP_SQ,
    OP_M_EVAL,
    OP_M_DEC,
    OP_I_RD,
    OP_I_LOAD,
    OP_J_EVAL,
    OP_I_DONE,
    OP_R_RD,
    OP_R_DATA,
    OP_OUT
  } op_t;

  typedef struct packed {
    op_t  op;
    logic use_cur;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       first;
    logic       last;
    logic       ret_nz;
    logic       scan_end;
    logic       i_end;
    logic       out_free;
  } dp_stat_t;

endpackage

/* hdl/ntu_ram.sv */
// ----------------------------------------------------------------------------
// ntu_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module ntu_ram #(
  parameter int WIDTH = 80,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hdl/ntu_ctrl.sv */
// ----------------------------------------------------------------------------
// ntu_ctrl
// Sequencer for ageing, matching, merging and reading of the track table.
// ----------------------------------------------------------------------------
module ntu_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  ntu_pkg::dp_stat_t stat,
  output ntu_pkg::ctrl_cmd_t cmd
);

  ntu_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ntu_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ntu_pkg::S_IDLE: begin
        if (in_tvalid) state_nxt = ntu_pkg::S_DISPATCH;
      end
      ntu_pkg::S_DISPATCH: begin
        unique case (stat.cmd)
          ntu_pkg::CMD_OBS:   state_nxt = (stat.first && stat.ret_nz) ?
                                          ntu_pkg::S_AGE_A : ntu_pkg::S_MATCH_A;
          ntu_pkg::CMD_SWEEP: state_nxt = stat.ret_nz ? ntu_pkg::S_AGE_A : ntu_pkg::S_MRG_A;
          ntu_pkg::CMD_READ:  state_nxt = ntu_pkg::S_READ_A;
          default:            state_nxt = ntu_pkg::S_IDLE;
        endcase
      end
      ntu_pkg::S_AGE_A: begin
        if (!stat.scan_end) state_nxt = ntu_pkg::S_AGE_B;
        else if (stat.cmd == ntu_pkg::CMD_SWEEP) state_nxt = ntu_pkg::S_MRG_A;
        else state_nxt = ntu_pkg::S_MATCH_A;
      end
      ntu_pkg::S_AGE_B:   state_nxt = ntu_pkg::S_AGE_A;
      ntu_pkg::S_MATCH_A: state_nxt = stat.scan_end ? ntu_pkg::S_MATCH_DEC : ntu_pkg::S_MATCH_B;
      ntu_pkg::S_MATCH_B: state_nxt = ntu_pkg::S_MATCH_C;
      ntu_pkg::S_MATCH_C: state_nxt = ntu_pkg::S_MATCH_D;
      ntu_pkg::S_MATCH_D: state_nxt = ntu_pkg::S_MATCH_A;
      ntu_pkg::S_MATCH_DEC: state_nxt = stat.last ? ntu_pkg::S_MRG_A : ntu_pkg::S_OUT;
      ntu_pkg::S_MRG_A:   state_nxt = stat.i_end ? ntu_pkg::S_OUT : ntu_pkg::S_MRG_B;
      ntu_pkg::S_MRG_B:   state_nxt = ntu_pkg::S_MRGJ_A;
      ntu_pkg::S_MRGJ_A:  state_nxt = stat.scan_end ? ntu_pkg::S_MRG_A : ntu_pkg::S_MRGJ_B;
      ntu_pkg::S_MRGJ_B:  state_nxt = ntu_pkg::S_MRGJ_C;
      ntu_pkg::S_MRGJ_C:  state_nxt = ntu_pkg::S_MRGJ_D;
      ntu_pkg::S_MRGJ_D:  state_nxt = ntu_pkg::S_MRGJ_A;
      ntu_pkg::S_READ_A:  state_nxt = ntu_pkg::S_READ_B;
      ntu_pkg::S_READ_B:  state_nxt = ntu_pkg::S_OUT;
      ntu_pkg::S_OUT: begin
        if (stat.out_free) state_nxt = ntu_pkg::S_IDLE;
      end
      default: state_nxt = ntu_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_tready   = 1'b0;
    cmd.op      = ntu_pkg::OP_NONE;
    cmd.use_cur = 1'b0;
    unique case (state_r)
      ntu_pkg::S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) cmd.op = ntu_pkg::OP_ACCEPT;
      end
      ntu_pkg::S_AGE_A:     cmd.op = stat.scan_end ? ntu_pkg::OP_AGE_DONE : ntu_pkg::OP_RD;
      ntu_pkg::S_AGE_B:     cmd.op = ntu_pkg::OP_AGE_EVAL;
      ntu_pkg::S_MATCH_A: begin
        if (!stat.scan_end) cmd.op = ntu_pkg::OP_RD;
      end
      ntu_pkg::S_MATCH_B:   cmd.op = ntu_pkg::OP_DIFF;
      ntu_pkg::S_MATCH_C:   cmd.op = ntu_pkg::OP_SQ;
      ntu_pkg::S_MATCH_D:   cmd.op = ntu_pkg::OP_M_EVAL;
      ntu_pkg::S_MATCH_DEC: cmd.op = ntu_pkg::OP_M_DEC;
      ntu_pkg::S_MRG_A: begin
        if (!stat.i_end) cmd.op = ntu_pkg::OP_I_RD;
      end
      ntu_pkg::S_MRG_B:     cmd.op = ntu_pkg::OP_I_LOAD;
      ntu_pkg::S_MRGJ_A:    cmd.op = stat.scan_end ? ntu_pkg::OP_I_DONE : ntu_pkg::OP_RD;
      ntu_pkg::S_MRGJ_B: begin
        cmd.op      = ntu_pkg::OP_DIFF;
        cmd.use_cur = 1'b1;
      end
      ntu_pkg::S_MRGJ_C:    cmd.op = ntu_pkg::OP_SQ;
      ntu_pkg::S_MRGJ_D:    cmd.op = ntu_pkg::OP_J_EVAL;
      ntu_pkg::S_READ_A:    cmd.op = ntu_pkg::OP_R_RD;
      ntu_pkg::S_READ_B:    cmd.op = ntu_pkg::OP_R_DATA;
      ntu_pkg::S_OUT: begin
        if (stat.out_free) cmd.op = ntu_pkg::OP_OUT;
      end
      default: cmd.op = ntu_pkg::OP_NONE;
    endcase
  end

endmodule

/* hdl/ntu_dp.sv */
// ----------------------------------------------------------------------------
// ntu_dp
// Track table storage, distance unit, scan pointers and result register.
// ----------------------------------------------------------------------------
module ntu_dp #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  ntu_pkg::ctrl_cmd_t cmd,
  output ntu_pkg::dp_stat_t  stat,
  input  logic [87:0]        in_tdata,
  input  logic [2:0]         in_tuser,
  input  logic               in_tlast,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [95:0]        out_tdata,
  output logic [2:0]         out_tuser,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [31:0]        cfg_wdata
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int RW = (CW > 4) ? CW : 4;
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  logic [15:0] ret_r;
  logic [31:0] radius_r;

  logic [1:0]  icmd_r;
  logic signed [15:0] px_r, py_r;
  logic [31:0] st_r;
  logic [15:0] pl_r;
  logic        first_r, last_r;
  logic [3:0]  rs_r;

  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] rp_r, rp_nxt, wp_r, wp_nxt, i_r, i_nxt;
  logic [AW-1:0] best_r, best_nxt;
  logic          found_r, found_nxt;
  logic [34:0]   bestd_r, bestd_nxt;
  ntu_pkg::entry_t cur_r, cur_nxt, ent_r;
  logic signed [16:0] dx_r, dy_r;
  logic [33:0]   sqx_r, sqy_r;

  logic [2:0]    res_status_r, res_status_nxt;
  logic [3:0]    res_slot_r, res_slot_nxt;
  ntu_pkg::entry_t res_ent_r, res_ent_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [95:0]   out_data_r;
  logic [2:0]    out_user_r;

  logic            ram_we;
  logic [AW-1:0]   ram_waddr, ram_raddr;
  ntu_pkg::entry_t ram_wdata, ram_rdata;

  ntu_pkg::entry_t item;
  ntu_pkg::entry_t op_a;
  logic [34:0]   dsq;
  logic signed [32:0] age;
  logic          rs_ok;
  logic signed [33:0] prodx, prody;

  ntu_ram #(.WIDTH(ntu_pkg::ENTRY_W), .DEPTH(TABLE_DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign item  = '{x: px_r, y: py_r, stamp: st_r, payload: pl_r};
  assign op_a  = cmd.use_cur ? cur_r : item;
  assign dsq   = {1'b0, sqx_r} + {1'b0, sqy_r};
  assign age   = $signed({1'b0, st_r}) - $signed({1'b0, ram_rdata.stamp});
  assign rs_ok = RW'(rs_r) < RW'(count_r);
  assign prodx = dx_r * dx_r;
  assign prody = dy_r * dy_r;

  assign stat.cmd      = icmd_r;
  assign stat.first    = first_r;
  assign stat.last     = last_r;
  assign stat.ret_nz   = ret_r != 16'd0;
  assign stat.scan_end = rp_r >= count_r;
  assign stat.i_end    = i_r >= count_r;
  assign stat.out_free = !out_valid_r || out_tready;

  always_comb begin
    count_nxt      = count_r;
    rp_nxt         = rp_r;
    wp_nxt         = wp_r;
    i_nxt          = i_r;
    best_nxt       = best_r;
    found_nxt      = found_r;
    bestd_nxt      = bestd_r;
    cur_nxt        = cur_r;
    res_status_nxt = res_status_r;
    res_slot_nxt   = res_slot_r;
    res_ent_nxt    = res_ent_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    ram_we         = 1'b0;
    ram_waddr      = wp_r[AW-1:0];
    ram_wdata      = ram_rdata;
    ram_raddr      = rp_r[AW-1:0];
    unique case (cmd.op)
      ntu_pkg::OP_ACCEPT: begin
        rp_nxt         = '0;
        wp_nxt         = '0;
        i_nxt          = '0;
        best_nxt       = '0;
        found_nxt      = 1'b0;
        bestd_nxt      = {3'b000, radius_r};
        res_ent_nxt    = '0;
        res_status_nxt = (in_tuser[1:0] == ntu_pkg::CMD_READ) ?
                         ntu_pkg::STAT_READ : ntu_pkg::STAT_SWEEP;
        res_slot_nxt   = (in_tuser[1:0] == ntu_pkg::CMD_READ) ? in_tdata[83:80] : 4'd0;
      end
      ntu_pkg::OP_AGE_EVAL: begin
        if (age <= $signed({17'd0, ret_r})) begin
          ram_we = 1'b1;
          wp_nxt = wp_r + 1'b1;
        end
        rp_nxt = rp_r + 1'b1;
      end
      ntu_pkg::OP_AGE_DONE: begin
        count_nxt = wp_r;
        rp_nxt    = '0;
      end
      ntu_pkg::OP_M_EVAL: begin
        if (dsq < bestd_r) begin
          bestd_nxt = dsq;
          best_nxt  = rp_r[AW-1:0];
          found_nxt = 1'b1;
        end
        rp_nxt = rp_r + 1'b1;
      end
      ntu_pkg::OP_M_DEC: begin
        ram_wdata = item;
        if (found_r) begin
          ram_we         = 1'b1;
          ram_waddr      = best_r;
          res_status_nxt = ntu_pkg::STAT_UPDATED;
          res_slot_nxt   = 4'(best_r);
        end else if (count_r < DEPTH_C) begin
          ram_we         = 1'b1;
          ram_waddr      = count_r[AW-1:0];
          count_nxt      = count_r + 1'b1;
          res_status_nxt = ntu_pkg::STAT_INSERTED;
          res_slot_nxt   = 4'(count_r);
        end else begin
          res_status_nxt = ntu_pkg::STAT_DROPPED;
          res_slot_nxt   = 4'd0;
        end
      end
      ntu_pkg::OP_I_RD: ram_raddr = i_r[AW-1:0];
      ntu_pkg::OP_I_LOAD: begin
        cur_nxt = ram_rdata;
        rp_nxt  = i_r + 1'b1;
        wp_nxt  = i_r + 1'b1;
      end
      ntu_pkg::OP_J_EVAL: begin
        ram_wdata = ent_r;
        if (dsq < {3'b000, radius_r}) begin
          if (cur_r.stamp < ent_r.stamp) cur_nxt = ent_r;
        end else begin
          ram_we = 1'b1;
          wp_nxt = wp_r + 1'b1;
        end
        rp_nxt = rp_r + 1'b1;
      end
      ntu_pkg::OP_I_DONE: begin
        ram_we    = 1'b1;
        ram_waddr = i_r[AW-1:0];
        ram_wdata = cur_r;
        count_nxt = wp_r;
        i_nxt     = i_r + 1'b1;
      end
      ntu_pkg::OP_R_RD: ram_raddr = AW'(rs_r);
      ntu_pkg::OP_R_DATA: begin
        if (rs_ok) res_ent_nxt = ram_rdata;
      end
      ntu_pkg::OP_OUT: out_valid_nxt = 1'b1;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ret_r       <= ntu_pkg::RETENTION_RESET;
      radius_r    <= ntu_pkg::RADIUS_RESET;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we && cfg_index == ntu_pkg::REG_RETENTION) ret_r <= cfg_wdata[15:0];
      if (cfg_we && cfg_index == ntu_pkg::REG_RADIUS) radius_r <= cfg_wdata;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rp_r         <= rp_nxt;
    wp_r         <= wp_nxt;
    i_r          <= i_nxt;
    best_r       <= best_nxt;
    found_r      <= found_nxt;
    bestd_r      <= bestd_nxt;
    cur_r        <= cur_nxt;
    res_status_r <= res_status_nxt;
    res_slot_r   <= res_slot_nxt;
    res_ent_r    <= res_ent_nxt;
    if (cmd.op == ntu_pkg::OP_ACCEPT) begin
      icmd_r  <= in_tuser[1:0];
      first_r <= in_tuser[2];
      last_r  <= in_tlast;
      px_r    <= in_tdata[15:0];
      py_r    <= in_tdata[31:16];
      st_r    <= in_tdata[63:32];
      pl_r    <= in_tdata[79:64];
      rs_r    <= in_tdata[83:80];
    end
    if (cmd.op == ntu_pkg::OP_DIFF) begin
      ent_r <= ram_rdata;
      dx_r  <= $signed({op_a.x[15], op_a.x}) - $signed({ram_rdata.x[15], ram_rdata.x});
      dy_r  <= $signed({op_a.y[15], op_a.y}) - $signed({ram_rdata.y[15], ram_rdata.y});
    end
    if (cmd.op == ntu_pkg::OP_SQ) begin
      sqx_r <= prodx[33:0];
      sqy_r <= prody[33:0];
    end
    if (cmd.op == ntu_pkg::OP_OUT) begin
      out_user_r <= res_status_r;
      out_data_r <= {7'd0, res_ent_r.payload, res_ent_r.stamp, res_ent_r.y, res_ent_r.x,
                     5'(count_r), res_slot_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

/* hdl/nearest_track_table_update_core.sv */
// ----------------------------------------------------------------------------
// nearest_track_table_update_core
// Ordered nearest-neighbour track table with ageing, matching and merging.
// ----------------------------------------------------------------------------
// One item is handled at a time; the table lives in a single RAM with one read
// and one write port, and every step of a scan goes through it. An observation
// runs a match scan over the entries, preceded by an ageing sweep on the first
// item of a batch when retention is nonzero, and followed by a merge pass on the
// last item. A finished result waits in the output register while the next item
// is taken.
module nearest_track_table_update_core #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [87:0] in_tdata,   // pos_x, pos_y, stamp, payload, read_slot
  input  logic [2:0]  in_tuser,   // cmd, first_in_batch
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [95:0] out_tdata,  // slot, track_count, out_x, out_y, out_stamp, out_payload
  output logic [2:0]  out_tuser,  // status
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_wdata
);

  ntu_pkg::ctrl_cmd_t cmd;
  ntu_pkg::dp_stat_t  stat;

  ntu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  ntu_dp #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

endmodule

/* test/nearest_track_table_update_core_tb.sv */
// ----------------------------------------------------------------------------
// nearest_track_table_update_core_tb
// Self-checking testbench for the nearest track table update core. A short
// directed table covers the reset state, field extremes, every command and the
// ignored command. Random batches of clustered observations, sweeps and reads
// follow under several register settings. Every result transfer is checked
// field by field against a typed directed row or a behavioural model in the bench.
// ----------------------------------------------------------------------------
module nearest_track_table_update_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH      = 16;
  localparam int SETTLE     = 800;
  localparam int IDLE_LIMIT = 20000;
  localparam int PHASE_ITEMS = 175;

  typedef struct {
    logic [1:0]         cmd;
    logic signed [15:0] px;
    logic signed [15:0] py;
    logic [31:0]        st;
    logic [15:0]        pl;
    logic               first;
    logic               last;
    logic [3:0]         rs;
  } obs_item_t;

  typedef struct {
    logic [2:0]         status;
    logic [3:0]         slot;
    logic [4:0]         count;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [31:0]        stamp;
    logic [15:0]        payload;
  } track_result_t;

  typedef struct {
    obs_item_t     item;
    bit            typed;
    track_result_t res;
  } directed_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [87:0] in_tdata = '0;
  logic [2:0]  in_tuser = '0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b1;
  logic [95:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [31:0] cfg_wdata = '0;

  nearest_track_table_update_core #(.TABLE_DEPTH(DEPTH)) uut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Model of the track table.
  ntu_pkg::entry_t tracks[DEPTH];
  int            n_tracks;
  logic [15:0]   retention;
  logic [31:0]   radius_sq;
  track_result_t pending_results[$];
  directed_row_t rows[$];

  int  err_cnt = 0;
  int  idle_cycles = 0;
  bit  quiet_in = 1'b0;
  bit  quiet_out = 1'b0;
  int  out_stall = 0;
  logic [31:0] now_ms = 32'd1000;
  int  batch_left = 0;
  logic signed [15:0] cx[8];
  logic signed [15:0] cy[8];

  function automatic longint unsigned sep_sq(ntu_pkg::entry_t a, ntu_pkg::entry_t b);
    longint dx, dy;
    dx = longint'(a.x) - longint'(b.x);
    dy = longint'(a.y) - longint'(b.y);
    return longint'(dx * dx) + longint'(dy * dy);
  endfunction

  function automatic void drop_track(int k);
    for (int m = k; m + 1 < n_tracks; m++) tracks[m] = tracks[m + 1];
    if (n_tracks > 0) n_tracks--;
  endfunction

  function automatic void age_tracks(logic [31:0] t_now);
    int k;
    longint age;
    k = 0;
    if (retention == 0) return;
    while (k < n_tracks) begin
      age = longint'(t_now) - longint'(tracks[k].stamp);
      if (age > longint'(retention)) drop_track(k);
      else k++;
    end
  endfunction

  function automatic void merge_tracks();
    int j;
    for (int i = 0; i < n_tracks; i++) begin
      j = i + 1;
      while (j < n_tracks) begin
        if (sep_sq(tracks[i], tracks[j]) < longint'(radius_sq)) begin
          if (tracks[i].stamp < tracks[j].stamp) tracks[i] = tracks[j];
          drop_track(j);
        end else begin
          j++;
        end
      end
    end
  endfunction

  function automatic bit predict_track_update(obs_item_t it, output track_result_t r);
    ntu_pkg::entry_t obs;
    longint unsigned best_d, d;
    int best;
    bit found;
    r = '{default: '0};
    if (it.cmd == ntu_pkg::CMD_NONE) return 1'b0;
    obs.x = it.px;
    obs.y = it.py;
    obs.stamp = it.st;
    obs.payload = it.pl;
    if (it.cmd == ntu_pkg::CMD_OBS) begin
      best = 0;
      found = 1'b0;
      best_d = longint'(radius_sq);
      if (it.first) age_tracks(it.st);
      for (int k = 0; k < n_tracks; k++) begin
        d = sep_sq(obs, tracks[k]);
        if (d < best_d) begin
          best_d = d;
          best = k;
          found = 1'b1;
        end
      end
      if (found) begin
        r.status = ntu_pkg::STAT_UPDATED;
      end else if (n_tracks < DEPTH) begin
        best = n_tracks;
        n_tracks++;
        r.status = ntu_pkg::STAT_INSERTED;
      end else begin
        r.status = ntu_pkg::STAT_DROPPED;
      end
      if (r.status != ntu_pkg::STAT_DROPPED) begin
        tracks[best] = obs;
        r.slot = best[3:0];
      end
      if (it.last) merge_tracks();
    end else if (it.cmd == ntu_pkg::CMD_SWEEP) begin
      age_tracks(it.st);
      merge_tracks();
      r.status = ntu_pkg::STAT_SWEEP;
    end else begin
      r.status = ntu_pkg::STAT_READ;
      r.slot = it.rs;
      if (int'(it.rs) < n_tracks) begin
        r.x = tracks[it.rs].x;
        r.y = tracks[it.rs].y;
        r.stamp = tracks[it.rs].stamp;
        r.payload = tracks[it.rs].payload;
      end
    end
    r.count = n_tracks[4:0];
    return 1'b1;
  endfunction

  function automatic obs_item_t mk(logic [1:0] cmd, int x, int y, logic [31:0] st,
                                   logic [15:0] pl, bit f, bit l, logic [3:0] rs);
    obs_item_t it;
    it.cmd = cmd;
    it.px = x[15:0];
    it.py = y[15:0];
    it.st = st;
    it.pl = pl;
    it.first = f;
    it.last = l;
    it.rs = rs;
    return it;
  endfunction

  function automatic track_result_t res(logic [2:0] s, logic [3:0] sl, logic [4:0] c);
    track_result_t r;
    r = '{default: '0};
    r.status = s;
    r.slot = sl;
    r.count = c;
    return r;
  endfunction

  function automatic void add_row(obs_item_t it, bit typed, track_result_t r);
    directed_row_t row;
    row.item = it;
    row.typed = typed;
    row.res = r;
    rows = {rows, row};
  endfunction

  task automatic send_item(obs_item_t it, bit typed, track_result_t typed_res);
    int gap;
    track_result_t r;
    gap = quiet_in ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {4'b0, it.rs, it.pl, it.st, it.py, it.px};
    in_tuser  <= {it.first, it.cmd};
    in_tlast  <= it.last;
    do @(posedge clk); while (!in_tready);
    if (predict_track_update(it, r)) begin
      pending_results = {pending_results, (typed ? typed_res : r)};
    end
  endtask

  task automatic write_reg(logic idx, logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == ntu_pkg::REG_RETENTION) retention = val[15:0];
    else radius_sq = val;
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic obs_item_t random_item();
    obs_item_t it;
    int r, c;
    it = mk(ntu_pkg::CMD_OBS, $urandom, $urandom, $urandom, 16'($urandom), 1'b0, 1'b0,
            4'($urandom));
    r = $urandom_range(0, 99);
    now_ms += $urandom_range(0, 400);
    if ($urandom_range(0, 29) == 0) now_ms = $urandom;
    it.st = ($urandom_range(0, 9) == 0) ? now_ms - $urandom_range(0, 3000) : now_ms;
    if (r < 5) begin
      it.cmd = ntu_pkg::CMD_NONE;
    end else if (r < 12) begin
      it.cmd = ntu_pkg::CMD_SWEEP;
    end else if (r < 25) begin
      it.cmd = ntu_pkg::CMD_READ;
    end else begin
      if (batch_left == 0) begin
        batch_left = $urandom_range(1, 6);
        it.first = 1'b1;
      end
      it.last = (batch_left == 1);
      batch_left--;
      if ($urandom_range(0, 9) == 0) begin
        it.first = 1'($urandom);
        it.last = 1'($urandom);
      end
      if ($urandom_range(0, 9) < 7) begin
        c = $urandom_range(0, 7);
        it.px = cx[c] + 16'($signed($urandom_range(0, 1600)) - 800);
        it.py = cy[c] + 16'($signed($urandom_range(0, 1600)) - 800);
      end
    end
    return it;
  endfunction

  // Result checker and receiver stalls.
  always @(posedge clk) begin
    track_result_t exp_r;
    if (out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result transfer");
        err_cnt++;
      end else begin
        exp_r = pending_results.pop_front();
        if (out_tuser !== exp_r.status) begin
          $error("status: expected %0d, got %0d", exp_r.status, out_tuser);
          err_cnt++;
        end
        if (out_tdata[3:0] !== exp_r.slot) begin
          $error("slot: expected %0d, got %0d", exp_r.slot, out_tdata[3:0]);
          err_cnt++;
        end
        if (out_tdata[8:4] !== exp_r.count) begin
          $error("track_count: expected %0d, got %0d", exp_r.count, out_tdata[8:4]);
          err_cnt++;
        end
        if (out_tdata[24:9] !== exp_r.x) begin
          $error("out_x: expected %0d, got %0d", exp_r.x, $signed(out_tdata[24:9]));
          err_cnt++;
        end
        if (out_tdata[40:25] !== exp_r.y) begin
          $error("out_y: expected %0d, got %0d", exp_r.y, $signed(out_tdata[40:25]));
          err_cnt++;
        end
        if (out_tdata[72:41] !== exp_r.stamp) begin
          $error("out_stamp: expected %0d, got %0d", exp_r.stamp, out_tdata[72:41]);
          err_cnt++;
        end
        if (out_tdata[88:73] !== exp_r.payload) begin
          $error("out_payload: expected %0d, got %0d", exp_r.payload, out_tdata[88:73]);
          err_cnt++;
        end
      end
      if ($urandom_range(0, 99) == 0) quiet_out = !quiet_out;
      out_stall = quiet_out ? 0 : $urandom_range(0, 11);
      out_tready <= (out_stall == 0);
    end else if (out_stall > 0) begin
      out_stall--;
      out_tready <= (out_stall == 0);
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    track_result_t none;
    logic [15:0] ret_set[6];
    logic [31:0] rad_set[6];
    int sent;
    obs_item_t it;

    none = '{default: '0};
    ret_set = '{16'd0, 16'd65535, 16'd100, 16'd1, 16'd5000, 16'd0};
    rad_set = '{32'd0, 32'hFFFF_FFFF, 32'd1000000, 32'd250000, 32'd4000000, 32'd1000000};
    for (int c = 0; c < 8; c++) begin
      cx[c] = 16'($urandom);
      cy[c] = 16'($urandom);
    end
    n_tracks = 0;
    retention = ntu_pkg::RETENTION_RESET;
    radius_sq = ntu_pkg::RADIUS_RESET;

    add_row(mk(ntu_pkg::CMD_READ, 0, 0, 0, 0, 0, 0, 0), 1,
            res(ntu_pkg::STAT_READ, 0, 0));
    add_row(mk(ntu_pkg::CMD_READ, 0, 0, 0, 0, 0, 0, 15), 1,
            res(ntu_pkg::STAT_READ, 15, 0));
    add_row(mk(ntu_pkg::CMD_OBS, -32768, 32767, 0, 16'hFFFF, 1, 0, 0), 1,
            res(ntu_pkg::STAT_INSERTED, 0, 1));
    add_row(mk(ntu_pkg::CMD_OBS, 32767, -32768, 32'hFFFF_FFFF, 0, 0, 0, 0), 1,
            res(ntu_pkg::STAT_INSERTED, 1, 2));
    add_row(mk(ntu_pkg::CMD_NONE, 0, 0, 0, 0, 0, 0, 0), 0, none);
    add_row(mk(ntu_pkg::CMD_READ, 0, 0, 0, 0, 0, 0, 1), 0, none);
    add_row(mk(ntu_pkg::CMD_OBS, -32700, 32700, 10, 16'h1234, 0, 0, 0), 1,
            res(ntu_pkg::STAT_UPDATED, 0, 2));
    add_row(mk(ntu_pkg::CMD_OBS, 100, 100, 20, 16'h00AA, 0, 1, 0), 0, none);
    add_row(mk(ntu_pkg::CMD_OBS, 400, 300, 25, 16'h5555, 1, 1, 0), 0, none);
    add_row(mk(ntu_pkg::CMD_SWEEP, 0, 0, 30, 0, 0, 0, 0), 0, none);
    add_row(mk(ntu_pkg::CMD_READ, 0, 0, 0, 0, 0, 0, 0), 0, none);
    add_row(mk(ntu_pkg::CMD_READ, 0, 0, 0, 0, 0, 0, 2), 0, none);
    add_row(mk(ntu_pkg::CMD_OBS, 0, 0, 32'h8000_0000, 16'hA5A5, 1, 1, 0), 0, none);
    add_row(mk(ntu_pkg::CMD_READ, 0, 0, 0, 0, 0, 0, 14), 0, none);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) send_item(rows[i].item, rows[i].typed, rows[i].res);

    for (int ph = 0; ph < 6; ph++) begin
      settle();
      write_reg(ntu_pkg::REG_RETENTION, {16'b0, ret_set[ph]});
      write_reg(ntu_pkg::REG_RADIUS, rad_set[ph]);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        if (sent % 40 == 0) quiet_in = ($urandom_range(0, 3) == 0);
        it = random_item();
        send_item(it, 1'b0, none);
        sent++;
      end
    end

    settle();
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
